@@ src/otsc_pkg.sv @@
// Package: shared types and constants for the oriented thruster slew controller.
package otsc_pkg;

   localparam int NumLegsDefault = 6;
   localparam int CordicSteps = 20;

   localparam logic [12:0] MagMax = 13'd6144;
   localparam logic [12:0] MagPark = 13'd205;
   localparam logic [31:0] RawRetractSq = 32'd168100;
   localparam logic [9:0] ScaleRetract = 10'd819;
   localparam logic [9:0] ScalePark = 10'd205;

   localparam logic [0:0] CsrParkAngle = 1'b0;
   localparam logic [0:0] CsrKneePoint = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQUARE_X,
      ST_SQUARE_Y,
      ST_CORDIC,
      ST_SQRT,
      ST_SELECT,
      ST_SLEW,
      ST_DIVIDE,
      ST_AMP,
      ST_DONE
   } state_type;

   function automatic logic [19:0] atan_entry(input logic [4:0] i);
      logic [19:0] v;
      case (i)
         5'd0: v = 20'd823550;
         5'd1: v = 20'd486170;
         5'd2: v = 20'd256879;
         5'd3: v = 20'd130396;
         5'd4: v = 20'd65451;
         5'd5: v = 20'd32757;
         5'd6: v = 20'd16383;
         5'd7: v = 20'd8192;
         5'd8: v = 20'd4096;
         5'd9: v = 20'd2048;
         5'd10: v = 20'd1024;
         5'd11: v = 20'd512;
         5'd12: v = 20'd256;
         5'd13: v = 20'd128;
         5'd14: v = 20'd64;
         5'd15: v = 20'd32;
         5'd16: v = 20'd16;
         5'd17: v = 20'd8;
         5'd18: v = 20'd4;
         5'd19: v = 20'd2;
         default: v = 20'd0;
      endcase
      return v;
   endfunction

endpackage

@@ src/otsc_if.sv @@
// Interfaces: request, response and register-write channels.
interface otsc_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  leg;
   logic signed [15:0] x_thrust;
   logic signed [15:0] y_thrust;
   logic [14:0] slew_limit;
   modport source (output valid, leg, x_thrust, y_thrust, slew_limit, input ready);
   modport sink (input valid, leg, x_thrust, y_thrust, slew_limit, output ready);
endinterface

interface otsc_rsp_if;
   logic        valid;
   logic        ready;
   logic [12:0] amplitude;
   logic signed [15:0] new_angle;
   modport source (output valid, amplitude, new_angle, input ready);
   modport sink (input valid, amplitude, new_angle, output ready);
endinterface

interface otsc_csr_if;
   logic        valid;
   logic        ready;
   logic [0:0]  index;
   logic [15:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

@@ src/oriented_thruster_slew_control.sv @@
// Top level: sequenced controller turning thrust demands into flipper angle and amplitude.
//
// Usage:
//   req_ carries one item per leg update: leg, x_thrust, y_thrust, slew_limit.
//   rsp_ returns one item per request: amplitude and the new flipper angle.
//   csr_ writes park_angle (index 0) and knee_point (index 1); always ready.
// A sequencer steps through the work, reusing a squarer and a multiplier:
//   the squares of x and y, 20 CORDIC iterations, 16 square-root iterations,
//   a select state, a slew state, 12 restoring-division iterations and
//   an amplitude state; the result is then held valid in the done state.
// The request side is ready only in idle; the next item is taken in the cycle
// after the result leaves, so only one item is worked on at a time.
// A stalled receiver holds the result in the output register and the block
// waits in its done state.
// Reset returns the sequencer to idle, clears every stored leg angle to zero
// and loads both registers with 3217. No clearing pass is needed.
module oriented_thruster_slew_control
   import otsc_pkg::*;
#(
   parameter int NUM_LEGS = NumLegsDefault
) (
   input logic clock,
   input logic reset,
   otsc_req_if.sink req_ch,
   otsc_rsp_if.source rsp_ch,
   otsc_csr_if.sink csr_ch
);

   localparam int LegW = (NUM_LEGS > 1) ? $clog2(NUM_LEGS) : 1;

   state_type state_ff, state_in;
   logic [4:0] cnt_ff, cnt_in;

   logic [13:0] park_ff;
   logic [14:0] knee_ff;
   logic signed [15:0] angle_ff [NUM_LEGS];

   logic [2:0] leg_ff;
   logic signed [15:0] x_ff, y_ff;
   logic [15:0] slew_ff, slew_in;
   logic [31:0] raw_ff, raw_in;
   logic signed [13:0] xc_ff;
   logic [12:0] yc_ff;
   logic signed [37:0] vx_ff, vx_in, vy_ff, vy_in;
   logic signed [24:0] z_ff, z_in;
   logic [31:0] rem_ff, rem_in, res_ff, res_in, bit_ff, bit_in;
   logic [12:0] mag_ff, mag_in;
   logic signed [16:0] target_ff, target_in;
   logic [17:0] adelta_ff, adelta_in;
   logic [32:0] div_ff, div_in;
   logic [12:0] quo_ff, quo_in;
   logic [12:0] amp_ff, amp_in;
   logic signed [15:0] newang_ff, newang_in;
   logic ratio_zero_ff, ratio_zero_in;

   logic leg_ok;
   logic [LegW-1:0] leg_idx;
   logic signed [15:0] cur;
   logic [14:0] knee;
   logic signed [31:0] sq;
   logic signed [15:0] sq_a;
   logic [27:0] mult;
   logic [14:0] mult_a;
   logic [12:0] mult_b;

   assign leg_ok = ({2'b00, leg_ff} < 5'(NUM_LEGS));
   assign leg_idx = LegW'(leg_ff);
   assign cur = leg_ok ? angle_ff[leg_idx] : 16'sd0;
   assign knee = (knee_ff == 15'd0) ? 15'd1 : knee_ff;
   assign sq = sq_a * sq_a;
   assign mult = mult_a * mult_b;
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign csr_ch.ready = 1'b1;
   assign rsp_ch.valid = (state_ff == ST_DONE);
   assign rsp_ch.amplitude = amp_ff;
   assign rsp_ch.new_angle = newang_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         park_ff <= 14'd3217;
         knee_ff <= 15'd3217;
         for (int i = 0; i < NUM_LEGS; i++) angle_ff[i] <= 16'sd0;
      end else begin
         state_ff <= state_in;
         if (csr_ch.valid) begin
            unique case (csr_ch.index)
               CsrParkAngle: park_ff <= csr_ch.data[13:0];
               CsrKneePoint: knee_ff <= csr_ch.data[14:0];
               default: ;
            endcase
         end
         if (state_ff == ST_AMP && leg_ok) angle_ff[leg_idx] <= newang_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      if (req_ch.valid && req_ch.ready) begin
         leg_ff <= req_ch.leg;
         x_ff <= req_ch.x_thrust;
         y_ff <= req_ch.y_thrust;
      end
      slew_ff <= (req_ch.valid && req_ch.ready) ? {1'b0, req_ch.slew_limit} : slew_in;
      raw_ff <= raw_in;
      if (state_ff == ST_SQUARE_X) begin
         xc_ff <= (x_ff > 16'sd6144) ? 14'sd6144 :
                  (x_ff < -16'sd6144) ? -14'sd6144 : x_ff[13:0];
         yc_ff <= (y_ff > 16'sd4096) ? 13'd4096 : (y_ff < 0) ? 13'd0 : y_ff[12:0];
      end
      vx_ff <= vx_in; vy_ff <= vy_in; z_ff <= z_in;
      rem_ff <= rem_in; res_ff <= res_in; bit_ff <= bit_in;
      mag_ff <= mag_in; target_ff <= target_in; adelta_ff <= adelta_in;
      div_ff <= div_in; quo_ff <= quo_in; amp_ff <= amp_in;
      newang_ff <= newang_in; ratio_zero_ff <= ratio_zero_in;
   end

   always_comb begin
      logic signed [37:0] dx, dy;
      logic [31:0] trial;
      logic signed [16:0] p, c17, delta, step, sl;
      logic [33:0] dtrial;
      logic [12:0] ratio;
      logic [27:0] amp_full;
      logic signed [31:0] xc_w;
      logic [31:0] yc_w;
      state_in = state_ff;
      cnt_in = cnt_ff;
      slew_in = slew_ff; raw_in = raw_ff;
      vx_in = vx_ff; vy_in = vy_ff; z_in = z_ff;
      rem_in = rem_ff; res_in = res_ff; bit_in = bit_ff;
      mag_in = mag_ff; target_in = target_ff; adelta_in = adelta_ff;
      div_in = div_ff; quo_in = quo_ff; amp_in = amp_ff;
      newang_in = newang_ff; ratio_zero_in = ratio_zero_ff;
      sq_a = x_ff;
      mult_a = slew_ff[14:0];
      mult_b = mag_ff;
      dx = vy_ff >>> cnt_ff;
      dy = vx_ff >>> cnt_ff;
      trial = res_ff + bit_ff;
      p = {3'b000, park_ff};
      c17 = {cur[15], cur};
      delta = target_ff - c17;
      sl = {1'b0, slew_ff};
      dtrial = {div_ff[32:0], 1'b0} - {19'd0, knee};
      ratio = 13'd4096 - quo_ff;
      amp_full = 28'd0;
      step = 17'sd0;
      xc_w = 32'(xc_ff);
      yc_w = {19'd0, yc_ff};
      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) state_in = ST_SQUARE_X;
         end
         ST_SQUARE_X: begin
            sq_a = x_ff;
            raw_in = sq;
            state_in = ST_SQUARE_Y;
         end
         ST_SQUARE_Y: begin
            sq_a = y_ff;
            raw_in = raw_ff + sq;
            vx_in = {{9{1'b0}}, yc_ff, 16'd0};
            vy_in = {{8{xc_ff[13]}}, xc_ff, 16'd0};
            z_in = 25'sd0;
            cnt_in = 5'd0;
            state_in = ST_CORDIC;
         end
         ST_CORDIC: begin
            if (vy_ff >= 0) begin
               vx_in = vx_ff + dx; vy_in = vy_ff - dy;
               z_in = z_ff + $signed({5'd0, atan_entry(cnt_ff)});
            end else begin
               vx_in = vx_ff - dx; vy_in = vy_ff + dy;
               z_in = z_ff - $signed({5'd0, atan_entry(cnt_ff)});
            end
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'(CordicSteps - 1)) begin
               rem_in = 32'(xc_w * xc_w) + yc_w * yc_w;
               res_in = 32'd0;
               bit_in = 32'h4000_0000;
               cnt_in = 5'd0;
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            // fixed 16 digit steps; leading zero steps leave res at zero
            if (rem_ff >= trial) begin
               rem_in = rem_ff - trial;
               res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd15) state_in = ST_SELECT;
         end
         ST_SELECT: begin
            mag_in = (res_ff > 32'(MagMax)) ? MagMax : res_ff[12:0];
            if (xc_ff == 0) target_in = 17'sd0;
            else target_in = 17'((z_ff + 25'sd128) >>> 8);
            state_in = ST_SLEW;
         end
         ST_SLEW: begin
            if (mag_ff < MagPark) begin
               if (raw_ff > RawRetractSq) begin
                  target_in = 17'sd0;
                  mult_b = {3'd0, ScaleRetract};
               end else begin
                  target_in = (c17 > p) ? p : (c17 < -p) ? -p : c17;
                  mult_b = {3'd0, ScalePark};
               end
            end
            slew_in = mult[27:12];
            delta = target_in - c17;
            adelta_in = delta[16] ? 18'(-delta) : {1'b0, delta};
            ratio_zero_in = (adelta_in >= {3'd0, knee});
            div_in = {15'd0, adelta_in};
            quo_in = 13'd0;
            cnt_in = 5'd0;
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            // restoring division of adelta*4096 by knee; adelta >= knee is flagged by ratio_zero
            if (!dtrial[33]) begin
               div_in = dtrial[32:0];
               quo_in = {quo_ff[11:0], 1'b1};
            end else begin
               div_in = {div_ff[31:0], 1'b0};
               quo_in = {quo_ff[11:0], 1'b0};
            end
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd11) state_in = ST_AMP;
         end
         ST_AMP: begin
            mult_a = ratio_zero_ff ? 15'd0 : {2'b00, ratio};
            amp_full = mult;
            amp_in = amp_full[24:12];
            step = (delta > sl) ? sl : (delta < -sl) ? -sl : delta;
            step = step + c17;
            newang_in = (step > 17'sd32767) ? 16'sh7fff :
                        (step < -17'sd32768) ? 16'sh8000 : step[15:0];
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_ch.ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

`ifndef NO_ASSERTIONS
   a_amp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> rsp_ch.amplitude <= MagMax)
      else $error("amplitude above 1.5");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.ready |=> rsp_ch.valid && $stable(rsp_ch.new_angle))
      else $error("result dropped while stalled");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> !req_ch.ready)
      else $error("request taken while busy");
   a_mag_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SLEW |-> mag_ff <= MagMax)
      else $error("magnitude not clamped");
`endif

endmodule
